@@ hw/rtl/bbg_pkg.sv @@
// Shared types and constants for the 3x3 grayscale box filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bbg_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int SUM_W      = 12;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  // floor(s / 9) == (s * RECIP_9) >> RECIP_SHIFT for every s up to 9 * 255
  localparam int RECIP_9     = 7282;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // what a pixel causes
  localparam logic [2:0] KIND_NONE  = 3'd0;  // nothing emitted
  localparam logic [2:0] KIND_SELF  = 3'd1;  // top row: pixel itself
  localparam logic [2:0] KIND_LEFT  = 3'd2;  // left column of the row above
  localparam logic [2:0] KIND_RIGHT = 3'd3;  // right column of the row above
  localparam logic [2:0] KIND_BLUR  = 3'd4;  // blurred pixel of the row above

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [COL_W-1:0] width_m1;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [2:0]       kind;
    logic             last_row;
  } desc_t;

  typedef struct packed {
    logic             two;
    logic [ROW_W-1:0] row0;
    logic [COL_W-1:0] col0;
    logic [PIX_W-1:0] pix0;
    logic [ROW_W-1:0] row1;
    logic [COL_W-1:0] col1;
    logic [PIX_W-1:0] pix1;
  } rec_t;

endpackage

@@ hw/rtl/box_blur_3x3_gray_unit.sv @@
// Top level of the 3x3 grayscale box filter: configuration registers and wiring.
// Depends on bbg_pkg, bbg_front, bbg_desc_fifo, bbg_back, bbg_result_fifo.
//
//   channel   direction  handshake              payload
//   input     in         push / full            pixel_in, frame_start
//   result    out        empty / pop            out_row, out_col, out_pixel, out_last
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel accepted per cycle while full is low; a pixel of the last row yields two
// results, so the result side needs two pops for it. A result passes through the
// descriptor queue, line store read, sum and reciprocal multiply into the result
// queue before it is on the result ports.
// The result queue admits new work by credit, so a held pop backs up into full.
// Reset clears counters, window and queues; line stores are not cleared.
`timescale 1ns / 1ps

module box_blur_3x3_gray_unit
  import bbg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             frame_start,
  output logic             empty,
  input  logic             pop,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [HGT_W-1:0] cfg_data
);

  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  cfg_t             cfg;
  logic             accept;
  desc_t            front_desc;
  desc_t            mq_head;
  logic             mq_empty;
  logic             mq_pop;
  logic [OQ_AW:0]   oq_count;
  logic             rec_push;
  rec_t             rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WID_W'(640);
      image_height <= HGT_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame size to what the line stores and counters hold
  always_comb begin
    if (image_width < WID_W'(MIN_DIM)) begin
      cfg.width = WID_W'(MIN_DIM);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      cfg.width = WID_W'(MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height < HGT_W'(MIN_DIM)) begin
      cfg.height = HGT_W'(MIN_DIM);
    end else if (image_height > HGT_W'(MAX_HEIGHT)) begin
      cfg.height = HGT_W'(MAX_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.width_m1 = COL_W'(cfg.width - WID_W'(1));
  end

  assign accept = push && !full;

  bbg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_in    (pixel_in),
    .frame_start (frame_start),
    .cfg         (cfg),
    .desc        (front_desc)
  );

  bbg_desc_fifo u_desc_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (front_desc),
    .full  (full),
    .rd    (mq_pop),
    .head  (mq_head),
    .empty (mq_empty)
  );

  bbg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mq_head  (mq_head),
    .mq_empty (mq_empty),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .rec_push (rec_push),
    .rec      (rec)
  );

  bbg_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .wdata     (rec),
    .count     (oq_count),
    .pop       (pop),
    .empty     (empty),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_pixel (out_pixel),
    .out_last  (out_last)
  );

endmodule

@@ hw/rtl/bbg_front.sv @@
// Front end: frame position counters and classification of each pixel.
// Depends on bbg_pkg.
`timescale 1ns / 1ps

module bbg_front
  import bbg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel_in,
  input  logic             frame_start,
  input  cfg_t             cfg,
  output desc_t            desc
);

  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count_next;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic [WID_W-1:0] col_inc;
  logic [HGT_W-1:0] row_inc;
  logic             in_frame;

  always_comb begin
    r_cur    = frame_start ? '0 : row_count;
    c_cur    = frame_start ? '0 : col_count;
    col_inc  = {1'b0, c_cur} + WID_W'(1);
    row_inc  = {1'b0, r_cur} + HGT_W'(1);
    in_frame = ({1'b0, r_cur} < cfg.height) && ({1'b0, c_cur} < cfg.width);

    if (col_inc >= cfg.width) begin
      col_count_next = '0;
      row_count_next = (row_inc >= cfg.height) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = r_cur;
    end

    desc.pix      = pixel_in;
    desc.row      = r_cur;
    desc.col      = c_cur;
    desc.last_row = in_frame && (r_cur >= ROW_W'(2)) &&
                    ({1'b0, r_cur} == (cfg.height - HGT_W'(1)));
    if (!in_frame || r_cur == ROW_W'(1)) begin
      desc.kind = KIND_NONE;
    end else if (r_cur == '0) begin
      desc.kind = KIND_SELF;
    end else if (c_cur == '0) begin
      desc.kind = KIND_LEFT;
    end else if (c_cur == COL_W'(1)) begin
      desc.kind = KIND_RIGHT;
    end else begin
      desc.kind = KIND_BLUR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

@@ hw/rtl/bbg_desc_fifo.sv @@
// Short queue of classified pixels between the front end and the filter back end.
// Depends on bbg_pkg.
`timescale 1ns / 1ps

module bbg_desc_fifo
  import bbg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  desc_t wdata,
  output logic  full,
  input  logic  rd,
  output desc_t head,
  output logic  empty
);

  desc_t            mem [MQ_DEPTH];
  logic [MQ_AW-1:0] wptr;
  logic [MQ_AW-1:0] rptr;
  logic [MQ_AW:0]   count;

  assign full  = (count == (MQ_AW+1)'(MQ_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + MQ_AW'(1);
      end
      if (rd) begin
        rptr <= rptr + MQ_AW'(1);
      end
      count <= count + (MQ_AW+1)'(wr) - (MQ_AW+1)'(rd);
    end
  end

`ifndef ASSERT_OFF
  a_mq_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (MQ_AW+1)'(MQ_DEPTH))
    else $error("descriptor queue count out of range");
`endif

endmodule

@@ hw/rtl/bbg_back.sv @@
// Back end: line stores, 3x3 window, neighbourhood sum and divide by 9.
// Depends on bbg_pkg; feeds bbg_result_fifo.
`timescale 1ns / 1ps

module bbg_back
  import bbg_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  desc_t           mq_head,
  input  logic            mq_empty,
  output logic            mq_pop,
  input  logic [OQ_AW:0]  oq_count,
  output logic            rec_push,
  output rec_t            rec
);

  logic [PIX_W-1:0] line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];

  // stage 1: line store data arrives
  logic             s1_valid;
  desc_t            s1_desc;
  logic [PIX_W-1:0] lp_a_raw;
  logic [PIX_W-1:0] lp_b_raw;
  logic [PIX_W-1:0] lp2_raw;
  logic             fwd_a;
  logic             fwd_b;
  logic [PIX_W-1:0] fwd_pix;
  logic [PIX_W-1:0] fwd_p1;
  logic [PIX_W-1:0] p1;
  logic [PIX_W-1:0] p2;
  logic [PIX_W-1:0] pr;
  logic [PIX_W-1:0] win [6];
  logic [SUM_W-1:0] sum;
  logic [OQ_AW:0]   credit_used;

  // stage 2: sum and result coordinates
  logic             s2_valid;
  logic             s2_blur;
  logic [SUM_W-1:0] s2_sum;
  rec_t             s2_rec;
  rec_t             s2_rec_next;
  logic [PROD_W-1:0] prod;

  assign credit_used = oq_count + (OQ_AW+1)'(s1_valid) + (OQ_AW+1)'(s2_valid);
  assign mq_pop      = !mq_empty && (credit_used < (OQ_AW+1)'(OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      lp_a_raw <= line_prev[mq_head.col];
      lp_b_raw <= line_prev[cfg.width_m1];
    end
    if (s1_valid) begin
      line_prev[s1_desc.col] <= s1_desc.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      lp2_raw <= line_prev2[mq_head.col];
    end
    if (s1_valid) begin
      line_prev2[s1_desc.col] <= p1;
    end
  end

  // forward the write of the item in stage 1 when the new read hits it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_a    <= 1'b0;
      fwd_b    <= 1'b0;
    end else begin
      s1_valid <= mq_pop;
      if (mq_pop) begin
        fwd_a <= s1_valid && (s1_desc.col == mq_head.col);
        fwd_b <= s1_valid && (s1_desc.col == cfg.width_m1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mq_pop) begin
      s1_desc <= mq_head;
      fwd_pix <= s1_desc.pix;
      fwd_p1  <= p1;
    end
  end

  assign p1 = fwd_a ? fwd_pix : lp_a_raw;
  assign p2 = fwd_a ? fwd_p1  : lp2_raw;
  assign pr = fwd_b ? fwd_pix : lp_b_raw;

  always_comb begin
    sum = SUM_W'(p2) + SUM_W'(p1) + SUM_W'(s1_desc.pix) +
          SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]) +
          SUM_W'(win[3]) + SUM_W'(win[4]) + SUM_W'(win[5]);

    s2_rec_next.two  = s1_desc.last_row;
    s2_rec_next.row1 = s1_desc.row;
    s2_rec_next.col1 = s1_desc.col;
    s2_rec_next.pix1 = s1_desc.pix;
    s2_rec_next.row0 = s1_desc.row - ROW_W'(1);
    s2_rec_next.col0 = s1_desc.col;
    s2_rec_next.pix0 = s1_desc.pix;
    case (s1_desc.kind)
      KIND_SELF: begin
        s2_rec_next.row0 = s1_desc.row;
      end
      KIND_LEFT: begin
        s2_rec_next.col0 = '0;
        s2_rec_next.pix0 = p1;
      end
      KIND_RIGHT: begin
        s2_rec_next.col0 = cfg.width_m1;
        s2_rec_next.pix0 = pr;
      end
      KIND_BLUR: begin
        s2_rec_next.col0 = s1_desc.col - COL_W'(1);
      end
      default: begin
        s2_rec_next.two = 1'b0;
      end
    endcase
  end

  // shift the window by one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= p2;
      win[4] <= p1;
      win[5] <= s1_desc.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_desc.kind != KIND_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_blur <= (s1_desc.kind == KIND_BLUR);
      s2_sum  <= sum;
      s2_rec  <= s2_rec_next;
    end
  end

  // divide by 9 through the reciprocal
  assign prod = PROD_W'(s2_sum) * PROD_W'(RECIP_9);

  always_comb begin
    rec = s2_rec;
    if (s2_blur) begin
      rec.pix0 = prod[RECIP_SHIFT +: PIX_W];
    end
  end

  assign rec_push = s2_valid;

`ifndef ASSERT_OFF
  a_credit: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((oq_count + (OQ_AW+1)'(s2_valid)) < (OQ_AW+1)'(OQ_DEPTH)))
    else $error("result queue credit overrun");
`endif

endmodule

@@ hw/rtl/bbg_result_fifo.sv @@
// Result queue: holds one or two results per pixel and hands them out one at a time.
// Depends on bbg_pkg.
`timescale 1ns / 1ps

module bbg_result_fifo
  import bbg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rec_t             wdata,
  output logic [OQ_AW:0]   count,
  input  logic             pop,
  output logic             empty,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last
);

  rec_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr;
  logic [OQ_AW-1:0] rptr;
  logic             sub;
  rec_t             head;
  logic             take;
  logic             done_rec;

  assign head      = mem[rptr];
  assign empty     = (count == '0);
  assign take      = pop && !empty;
  assign done_rec  = take && (!head.two || sub);
  assign out_row   = sub ? head.row1 : head.row0;
  assign out_col   = sub ? head.col1 : head.col0;
  assign out_pixel = sub ? head.pix1 : head.pix0;
  assign out_last  = !head.two || sub;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      sub   <= 1'b0;
    end else begin
      if (push) begin
        wptr <= wptr + OQ_AW'(1);
      end
      if (done_rec) begin
        rptr <= rptr + OQ_AW'(1);
        sub  <= 1'b0;
      end else if (take) begin
        sub <= 1'b1;
      end
      count <= count + (OQ_AW+1)'(push) - (OQ_AW+1)'(done_rec);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != (OQ_AW+1)'(OQ_DEPTH)))
    else $error("result queue overflow");
  a_second_valid: assert property (@(posedge clk) disable iff (rst)
    sub |-> (!empty && head.two))
    else $error("second result selected on a single-result entry");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for box_blur_3x3_gray_unit, the streaming 3x3 box filter.
// Drives pixels and register writes with random idling and predicts every result.
// Depends on bbg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;
  import bbg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned WINDOW_TAPS = 9;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned SCRIPT_LEN = 25;
  localparam int unsigned ITEM_COUNT = 1100;
  localparam int unsigned PRESSURE_AT = 500;
  localparam int unsigned PRESSURE_CYCLES = 400;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             last;
  } px_result_t;

  // one directed transaction; t_row/t_col hold a typed result when typed is set
  typedef struct packed {
    logic             set_dims;
    logic [HGT_W-1:0] w_val;
    logic [HGT_W-1:0] h_val;
    logic [PIX_W-1:0] pix;
    logic             fs;
    logic             typed;
    logic [ROW_W-1:0] t_row;
    logic [COL_W-1:0] t_col;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             push;
  logic             full;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  logic             empty;
  logic             pop;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] out_pixel;
  logic             out_last;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [HGT_W-1:0] cfg_data;

  // predictor state
  int unsigned above_line [MAX_WIDTH];
  int unsigned above2_line [MAX_WIDTH];
  int unsigned win_taps [6];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned width_reg;
  int unsigned height_reg;
  px_result_t  filtered_q [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned pixels_in = 0;
  logic        steady = 1'b0;
  logic        pop_hold = 1'b0;

  script_row_t script [SCRIPT_LEN] = '{
    // right after reset: default frame, top row copies through
    '{1'b0, 13'd0,    13'd0,    8'h5A, 1'b0, 1'b1, 12'd0, 10'd0},
    // smallest frame
    '{1'b1, 13'd3,    13'd3,    8'h00, 1'b1, 1'b1, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b1, 12'd0, 10'd1},
    '{1'b0, 13'd0,    13'd0,    8'h80, 1'b0, 1'b1, 12'd0, 10'd2},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'h00, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    // next frame follows by wrap, all full scale for the largest sum
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b1, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b1, 12'd0, 10'd1},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b1, 12'd0, 10'd2},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    // all-ones register data: both dimensions clamp high
    '{1'b1, 13'd8191, 13'd8191, 8'h01, 1'b1, 1'b1, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'h02, 1'b0, 1'b1, 12'd0, 10'd1},
    '{1'b0, 13'd0,    13'd0,    8'h03, 1'b0, 1'b1, 12'd0, 10'd2},
    '{1'b0, 13'd0,    13'd0,    8'h04, 1'b0, 1'b1, 12'd0, 10'd3},
    // shrink below the current column: pixel falls outside, counters wrap
    '{1'b1, 13'd0,    13'd2,    8'hFF, 1'b0, 1'b0, 12'd0, 10'd0},
    '{1'b0, 13'd0,    13'd0,    8'h07, 1'b1, 1'b1, 12'd0, 10'd0}
  };

  box_blur_3x3_gray_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel_in   (pixel_in),
    .frame_start(frame_start),
    .empty      (empty),
    .pop        (pop),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_pixel  (out_pixel),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
  endfunction

  function automatic px_result_t make_result(int unsigned row, int unsigned col,
                                             int unsigned pix);
    return {ROW_W'(row), COL_W'(col), PIX_W'(pix), 1'b0};
  endfunction

  function automatic int unsigned idle_cycles();
    if (steady) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned draw_dim(int unsigned top, int unsigned usual);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2);
      1:       return 8191;
      2:       return top;
      3:       return MIN_DIM;
      default: return $urandom_range(4, usual);
    endcase
  endfunction

  // Advance the filter by one pixel and queue the results it causes.
  task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    px_result_t  res [2];
    int unsigned w, h, r, c, pv, p1, p2, sum, n;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    pv = 32'(pix);
    n = 0;
    if (fs) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row;
    c = cur_col;
    p2 = above2_line[c];
    p1 = above_line[c];
    if (r < h && c < w) begin
      if (r == 0) begin
        res[n] = make_result(0, c, pv);
        n++;
      end else if (r >= 2) begin
        // the row above is finished one column late: edges copied, interior blurred
        if (c == 0) begin
          res[n] = make_result(r - 1, 0, p1);
        end else if (c == 1) begin
          res[n] = make_result(r - 1, w - 1, above_line[w - 1]);
        end else begin
          sum = p2 + p1 + pv;
          for (int i = 0; i < 6; i++) sum += win_taps[i];
          res[n] = make_result(r - 1, c - 1, sum / WINDOW_TAPS);
        end
        n++;
        if (r == h - 1) begin
          res[n] = make_result(r, c, pv);
          n++;
        end
      end
    end
    above2_line[c] = p1;
    above_line[c] = pv;
    win_taps[0] = win_taps[3];
    win_taps[1] = win_taps[4];
    win_taps[2] = win_taps[5];
    win_taps[3] = p2;
    win_taps[4] = p1;
    win_taps[5] = pv;
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFF);
    end else begin
      cur_col = (c + 1) & 32'h3FF;
    end
    if (n > 0) begin
      res[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) filtered_q.push_back(res[i]);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic typed,
                            input logic [ROW_W-1:0] trow, input logic [COL_W-1:0] tcol);
    int unsigned gap;
    int unsigned n0;
    gap = idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pixel_in <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_in++;
    n0 = filtered_q.size();
    filter_pixel(pix, fs);
    if (typed) begin
      while (filtered_q.size() > n0) void'(filtered_q.pop_back());
      filtered_q.push_back({trow, tcol, pix, 1'b1});
    end
  endtask

  // Hold the input and wait until the block has nothing left in flight.
  task automatic settle();
    push <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [HGT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = 32'(val[WID_W-1:0]);
    else height_reg = 32'(val);
  endtask

  task automatic write_dims(input logic [HGT_W-1:0] w_val, input logic [HGT_W-1:0] h_val);
    write_reg(REG_IMAGE_WIDTH, w_val);
    write_reg(REG_IMAGE_HEIGHT, h_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_result();
    px_result_t got;
    px_result_t want;
    got = {out_row, out_col, out_pixel, out_last};
    if (filtered_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result at %0t: row %0d col %0d pix %0d last %0d",
                 $realtime, got.row, got.col, got.pix, got.last);
    end else begin
      want = filtered_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch at %0t: expected row %0d col %0d pix %0d last %0d,",
                    " got %0d %0d %0d %0d"},
                   $realtime, want.row, want.col, want.pix, want.last,
                   got.row, got.col, got.pix, got.last);
      end
    end
  endtask

  // result side
  initial begin : drain
    int unsigned gap;
    pop <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0 || pop_hold) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
        while (pop_hold) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result();
    end
  end

  // long stall on the result side so the block backs up into full
  initial begin : pressure
    wait (pixels_in >= PRESSURE_AT);
    pop_hold <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    pop_hold <= 1'b0;
  end

  initial begin : stimulus
    int unsigned w_eff, h_eff, len, frames;
    logic        fs;
    logic        wrote;
    push <= 1'b0;
    pixel_in <= '0;
    frame_start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    rst <= 1'b1;
    width_reg = 640;
    height_reg = 480;
    cur_row = 0;
    cur_col = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      above_line[i] = 0;
      above2_line[i] = 0;
    end
    for (int i = 0; i < 6; i++) win_taps[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].set_dims) begin
        settle();
        write_dims(script[i].w_val, script[i].h_val);
      end
      send_pixel(script[i].pix, script[i].fs, script[i].typed, script[i].t_row,
                 script[i].t_col);
    end

    while (pixels_in < ITEM_COUNT) begin
      settle();
      wrote = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        write_dims(HGT_W'(draw_dim(MAX_WIDTH, 12)), HGT_W'(draw_dim(MAX_HEIGHT, 8)));
        wrote = 1'b1;
      end
      steady = ($urandom_range(0, 3) == 0);
      w_eff = clamp_dim(width_reg, MAX_WIDTH);
      h_eff = clamp_dim(height_reg, MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && pixels_in < ITEM_COUNT; f++) begin
        len = w_eff * h_eff;
        if (len > 200) len = $urandom_range(20, 200);
        for (int i = 0; i < len && pixels_in < ITEM_COUNT; i++) begin
          // a new frame size always restarts the frame so every line-store entry
          // is written before it is read; otherwise mostly aligned frames, with
          // an occasional stray restart or a missing one
          if (i == 0 && f == 0) fs = wrote || ($urandom_range(0, 3) != 0);
          else if (i == 0) fs = 1'($urandom_range(0, 1));
          else fs = ($urandom_range(0, 39) == 0);
          send_pixel(random_pixel(), fs, 1'b0, '0, '0);
        end
      end
    end

    steady = 1'b0;
    settle();
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
